// ----- hw/rtl/triangle_face_normal_assert.svh -----
// Assertion macros shared by the triangle face normal RTL.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define TFN_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define TFN_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TFN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tfn_pkg.sv -----
// Shared widths, codes and types for the triangle face normal block.
package tfn_pkg;

    // Field widths
    localparam int COORD_W    = 24;
    localparam int INDEX_W    = 10;
    localparam int NORM_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int ENTRY_W    = 3 * COORD_W;

    // Stream bus widths
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 64;

    // Datapath widths
    localparam int EDGE_W     = COORD_W + 1;
    localparam int CROSS_W    = 2 * EDGE_W + 1;
    localparam int MAG_W      = CROSS_W - 1;
    localparam int NMAG_W     = 30;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 64;
    localparam int WIDE_W     = 64;
    localparam int DIV_W      = 46;
    localparam int QUO_W      = 15;
    localparam int FRAC_W     = 14;

    // Operation codes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_FACE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_AREA = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // Result of the shared compare-subtract unit
    typedef struct packed {
        logic              ge;
        logic [WIDE_W-1:0] diff;
    } csub_res_t;

endpackage

// ----- hw/rtl/tfn_corner_mem.sv -----
// Corner position table: one write port, one registered read port.
module tfn_corner_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [tfn_pkg::ENTRY_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [tfn_pkg::ENTRY_W-1:0] rdata
);

    logic [tfn_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [tfn_pkg::ENTRY_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tfn_mul.sv -----
// Shared signed multiplier with registered product.
module tfn_mul (
    input  logic                             clk,
    input  logic signed [tfn_pkg::MUL_W-1:0] a,
    input  logic signed [tfn_pkg::MUL_W-1:0] b,
    output logic signed [tfn_pkg::PROD_W-1:0] p
);

    logic signed [tfn_pkg::PROD_W-1:0] p_reg;

    // One product per cycle, available the next cycle
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ----- hw/rtl/tfn_csub.sv -----
// Shared wide compare-subtract step for square root and division.
module tfn_csub (
    input  logic [tfn_pkg::WIDE_W-1:0] a,
    input  logic [tfn_pkg::WIDE_W-1:0] b,
    output tfn_pkg::csub_res_t         res
);

    logic [tfn_pkg::WIDE_W:0] sub;

    // Borrow out of a - b says a < b
    assign sub      = {1'b0, a} - {1'b0, b};
    assign res.ge   = ~sub[tfn_pkg::WIDE_W];
    assign res.diff = sub[tfn_pkg::WIDE_W-1:0];

endmodule

// ----- hw/rtl/triangle_face_normal.sv -----
// Triangle face normal: corner table plus sequenced cross product and normalize.
//
//  channel  | role   | tdata (low bit up)                                  | tuser
//  ---------+--------+-----------------------------------------------------+----------
//  s_axis   | input  | pos_x, pos_y, pos_z, corner_a, corner_b, corner_c   | operation
//  m_axis   | output | normal_x, normal_y, normal_z, stored_index          | status
//
//  Store and bad-index items go from accept to the finish state and then to the
//  result register. A face item runs through table reads, the cross product on
//  the shared multiplier, single-bit normalize shifts, the sum of squares, 32
//  root steps and a restoring divide for each component, the last two on one
//  shared compare-subtract unit. One item is worked on at a time.
//  Reset clears the corner count and control state, not the table; the table needs no clearing pass.
//  A held result in the output register does not block the next accept.
`include "triangle_face_normal_assert.svh"

module triangle_face_normal #(
    parameter int MAX_CORNERS = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x[23:0], pos_y[47:24], pos_z[71:48], corner_a[81:72],
    // corner_b[91:82], corner_c[101:92], zero fill[103:102]
    input  logic [tfn_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // normal_x[15:0], normal_y[31:16], normal_z[47:32], stored_index[57:48],
    // zero fill[63:58]
    output logic [tfn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status[2:0]
    output logic [tfn_pkg::STATUS_W-1:0]    m_axis_tuser
);

    localparam int AW = $clog2(MAX_CORNERS);
    localparam int CW = $clog2(MAX_CORNERS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_CORNERS);

    localparam int COORD_W = tfn_pkg::COORD_W;
    localparam int INDEX_W = tfn_pkg::INDEX_W;
    localparam int NORM_W  = tfn_pkg::NORM_W;
    localparam int EDGE_W  = tfn_pkg::EDGE_W;
    localparam int CROSS_W = tfn_pkg::CROSS_W;
    localparam int MAG_W   = tfn_pkg::MAG_W;
    localparam int NMAG_W  = tfn_pkg::NMAG_W;
    localparam int MUL_W   = tfn_pkg::MUL_W;
    localparam int WIDE_W  = tfn_pkg::WIDE_W;
    localparam int DIV_W   = tfn_pkg::DIV_W;
    localparam int QUO_W   = tfn_pkg::QUO_W;
    localparam int FRAC_W  = tfn_pkg::FRAC_W;
    localparam int PAD_W   = tfn_pkg::OUT_DATA_W - 3 * NORM_W - INDEX_W;

    localparam logic [WIDE_W-1:0] ROOT_BIT0 = WIDE_W'(64'h4000_0000_0000_0000);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_READ   = 4'd1;
    localparam logic [3:0] S_CROSS  = 4'd2;
    localparam logic [3:0] S_ABS    = 4'd3;
    localparam logic [3:0] S_NORM   = 4'd4;
    localparam logic [3:0] S_SQUARE = 4'd5;
    localparam logic [3:0] S_SQRT   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    localparam logic [3:0] READ_LAST   = 4'd3;
    localparam logic [3:0] CROSS_LAST  = 4'd6;
    localparam logic [3:0] SQUARE_LAST = 4'd3;
    localparam logic [3:0] DIV_LAST    = 4'd15;
    localparam logic [1:0] COMP_LAST   = 2'd2;

    // Control state
    logic [3:0]    state_reg;
    logic [3:0]    step_reg;
    logic [1:0]    comp_reg;
    logic [CW-1:0] count_reg;
    logic          out_valid_reg;

    // Payload state
    logic [AW-1:0]                    ia_reg, ib_reg, ic_reg;
    logic signed [COORD_W-1:0]        c0x_reg, c0y_reg, c0z_reg;
    logic signed [EDGE_W-1:0]         e1x_reg, e1y_reg, e1z_reg;
    logic signed [EDGE_W-1:0]         e2x_reg, e2y_reg, e2z_reg;
    logic signed [CROSS_W-1:0]        acc_reg;
    logic signed [CROSS_W-1:0]        crx_reg, cry_reg, crz_reg;
    logic [MAG_W-1:0]                 mx_reg, my_reg, mz_reg;
    logic                             sx_reg, sy_reg, sz_reg;
    logic [WIDE_W-1:0]                v_reg, r_reg, bit_reg;
    logic [DIV_W-1:0]                 rem_reg, d_reg;
    logic [QUO_W-1:0]                 q_reg;
    logic [NORM_W-1:0]                nx_reg, ny_reg, nz_reg;
    logic [tfn_pkg::STATUS_W-1:0]     status_reg;
    logic [INDEX_W-1:0]               sidx_reg;
    logic [tfn_pkg::OUT_DATA_W-1:0]   out_data_reg;
    logic [tfn_pkg::STATUS_W-1:0]     out_user_reg;

    // Input unpack
    logic                      s_fire, m_fire, out_load;
    logic                      in_op;
    logic [COORD_W-1:0]        in_pos_x, in_pos_y, in_pos_z;
    logic [INDEX_W-1:0]        in_corner_a, in_corner_b, in_corner_c;
    logic [31:0]               ia_ext, ib_ext, ic_ext, cnt_ext;
    logic                      idx_ok, table_full;
    logic [INDEX_W-1:0]        count_idx;

    assign s_fire      = s_axis_tvalid & s_axis_tready;
    assign m_fire      = m_axis_tvalid & m_axis_tready;
    assign in_op       = s_axis_tuser;
    assign in_pos_x    = s_axis_tdata[23:0];
    assign in_pos_y    = s_axis_tdata[47:24];
    assign in_pos_z    = s_axis_tdata[71:48];
    assign in_corner_a = s_axis_tdata[81:72];
    assign in_corner_b = s_axis_tdata[91:82];
    assign in_corner_c = s_axis_tdata[101:92];

    assign ia_ext     = 32'(in_corner_a);
    assign ib_ext     = 32'(in_corner_b);
    assign ic_ext     = 32'(in_corner_c);
    assign cnt_ext    = 32'(count_reg);
    assign idx_ok     = (ia_ext < cnt_ext) && (ib_ext < cnt_ext) && (ic_ext < cnt_ext);
    assign table_full = (count_reg == FULL_COUNT);
    assign count_idx  = cnt_ext[INDEX_W-1:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_load      = (state_reg == S_FINISH) && (!out_valid_reg || m_axis_tready);

    // Corner table
    logic                         mem_we, mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [tfn_pkg::ENTRY_W-1:0]  mem_rdata;
    logic signed [COORD_W-1:0]    rd_x, rd_y, rd_z;

    assign mem_we = s_fire && (in_op == tfn_pkg::OP_STORE) && !table_full;
    assign mem_re = (state_reg == S_READ);

    always_comb
    begin
        case (step_reg)
            4'd0:    mem_raddr = ia_reg;
            4'd1:    mem_raddr = ib_reg;
            default: mem_raddr = ic_reg;
        endcase
    end

    tfn_corner_mem #(
        .DEPTH (MAX_CORNERS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({in_pos_z, in_pos_y, in_pos_x}),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_x = mem_rdata[COORD_W-1:0];
    assign rd_y = mem_rdata[2*COORD_W-1:COORD_W];
    assign rd_z = mem_rdata[3*COORD_W-1:2*COORD_W];

    // Shared multiplier operand select
    logic signed [MUL_W-1:0]          mul_a, mul_b;
    logic signed [tfn_pkg::PROD_W-1:0] prod;
    logic signed [CROSS_W-1:0]        prod_lo;
    logic [WIDE_W-1:0]                prod_u;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_CROSS)
        begin
            case (step_reg)
                4'd0:    begin mul_a = MUL_W'(e1y_reg); mul_b = MUL_W'(e2z_reg); end
                4'd1:    begin mul_a = MUL_W'(e1z_reg); mul_b = MUL_W'(e2y_reg); end
                4'd2:    begin mul_a = MUL_W'(e1z_reg); mul_b = MUL_W'(e2x_reg); end
                4'd3:    begin mul_a = MUL_W'(e1x_reg); mul_b = MUL_W'(e2z_reg); end
                4'd4:    begin mul_a = MUL_W'(e1x_reg); mul_b = MUL_W'(e2y_reg); end
                4'd5:    begin mul_a = MUL_W'(e1y_reg); mul_b = MUL_W'(e2x_reg); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == S_SQUARE)
        begin
            case (step_reg)
                4'd0:    begin mul_a = MUL_W'(mx_reg[NMAG_W-1:0]);
                               mul_b = MUL_W'(mx_reg[NMAG_W-1:0]); end
                4'd1:    begin mul_a = MUL_W'(my_reg[NMAG_W-1:0]);
                               mul_b = MUL_W'(my_reg[NMAG_W-1:0]); end
                4'd2:    begin mul_a = MUL_W'(mz_reg[NMAG_W-1:0]);
                               mul_b = MUL_W'(mz_reg[NMAG_W-1:0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    tfn_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign prod_lo = prod[CROSS_W-1:0];
    assign prod_u  = prod;

    // Magnitudes and normalize decision
    logic signed [CROSS_W-1:0] crx_neg, cry_neg, crz_neg;
    logic [MAG_W-1:0]          mag_or;
    logic                      norm_hi, norm_lo;
    logic                      cross_zero;

    assign crx_neg    = -crx_reg;
    assign cry_neg    = -cry_reg;
    assign crz_neg    = -crz_reg;
    assign cross_zero = (crx_reg == '0) && (cry_reg == '0) && (crz_reg == '0);
    assign mag_or     = mx_reg | my_reg | mz_reg;
    assign norm_hi    = |mag_or[MAG_W-1:NMAG_W];
    assign norm_lo    = !mag_or[NMAG_W-1];

    // Shared compare-subtract operand select
    logic [WIDE_W-1:0]  cs_a, cs_b;
    tfn_pkg::csub_res_t cs_res;

    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            cs_a = v_reg;
            cs_b = r_reg | bit_reg;
        end
        else
        begin
            cs_a = WIDE_W'(rem_reg);
            cs_b = WIDE_W'(d_reg);
        end
    end

    tfn_csub u_csub (
        .a   (cs_a),
        .b   (cs_b),
        .res (cs_res)
    );

    // Divide set-up and final quotient
    logic [NMAG_W-1:0] mag_sel;
    logic              sign_sel;
    logic [DIV_W-1:0]  div_num, div_den;
    logic [QUO_W-1:0]  q_next;
    logic [NORM_W-1:0] q_ext, n_val;

    always_comb
    begin
        case (comp_reg)
            2'd0:    begin mag_sel = mx_reg[NMAG_W-1:0]; sign_sel = sx_reg; end
            2'd1:    begin mag_sel = my_reg[NMAG_W-1:0]; sign_sel = sy_reg; end
            default: begin mag_sel = mz_reg[NMAG_W-1:0]; sign_sel = sz_reg; end
        endcase
    end

    // (mag * 2^14 + r / 2) over r
    assign div_num = DIV_W'({mag_sel, {FRAC_W{1'b0}}}) + DIV_W'(r_reg[31:1]);
    assign div_den = DIV_W'({r_reg[30:0], {FRAC_W{1'b0}}});
    assign q_next  = {q_reg[QUO_W-2:0], cs_res.ge};
    assign q_ext   = NORM_W'(q_next);
    assign n_val   = sign_sel ? (~q_ext + 1'b1) : q_ext;

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            comp_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (s_fire)
                    begin
                        if (in_op == tfn_pkg::OP_STORE)
                        begin
                            state_reg <= S_FINISH;
                            if (!table_full)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        else if (idx_ok)
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_READ:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == READ_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_CROSS;
                    end
                end
                S_CROSS:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == CROSS_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_ABS;
                    end
                end
                S_ABS:
                begin
                    state_reg <= cross_zero ? S_FINISH : S_NORM;
                end
                S_NORM:
                begin
                    if (!norm_hi && !norm_lo)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == SQUARE_LAST)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        step_reg  <= '0;
                        comp_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == DIV_LAST)
                    begin
                        step_reg <= '0;
                        if (comp_reg == COMP_LAST)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 1'b1;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    nx_reg <= '0;
                    ny_reg <= '0;
                    nz_reg <= '0;
                    ia_reg <= ia_ext[AW-1:0];
                    ib_reg <= ib_ext[AW-1:0];
                    ic_reg <= ic_ext[AW-1:0];
                    if (in_op == tfn_pkg::OP_STORE)
                    begin
                        status_reg <= table_full ? tfn_pkg::ST_FULL : tfn_pkg::ST_STORED;
                        sidx_reg   <= table_full ? '0 : count_idx;
                    end
                    else
                    begin
                        status_reg <= idx_ok ? tfn_pkg::ST_OK : tfn_pkg::ST_BAD_INDEX;
                        sidx_reg   <= '0;
                    end
                end
            end
            S_READ:
            begin
                case (step_reg)
                    4'd1:
                    begin
                        c0x_reg <= rd_x;
                        c0y_reg <= rd_y;
                        c0z_reg <= rd_z;
                    end
                    4'd2:
                    begin
                        e1x_reg <= EDGE_W'(rd_x) - EDGE_W'(c0x_reg);
                        e1y_reg <= EDGE_W'(rd_y) - EDGE_W'(c0y_reg);
                        e1z_reg <= EDGE_W'(rd_z) - EDGE_W'(c0z_reg);
                    end
                    4'd3:
                    begin
                        e2x_reg <= EDGE_W'(rd_x) - EDGE_W'(c0x_reg);
                        e2y_reg <= EDGE_W'(rd_y) - EDGE_W'(c0y_reg);
                        e2z_reg <= EDGE_W'(rd_z) - EDGE_W'(c0z_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CROSS:
            begin
                // Products arrive in the cycle after their operands
                case (step_reg)
                    4'd1, 4'd3, 4'd5: acc_reg <= prod_lo;
                    4'd2:             crx_reg <= acc_reg - prod_lo;
                    4'd4:             cry_reg <= acc_reg - prod_lo;
                    4'd6:             crz_reg <= acc_reg - prod_lo;
                    default:
                    begin
                    end
                endcase
            end
            S_ABS:
            begin
                sx_reg <= crx_reg[CROSS_W-1];
                sy_reg <= cry_reg[CROSS_W-1];
                sz_reg <= crz_reg[CROSS_W-1];
                mx_reg <= crx_reg[CROSS_W-1] ? crx_neg[MAG_W-1:0] : crx_reg[MAG_W-1:0];
                my_reg <= cry_reg[CROSS_W-1] ? cry_neg[MAG_W-1:0] : cry_reg[MAG_W-1:0];
                mz_reg <= crz_reg[CROSS_W-1] ? crz_neg[MAG_W-1:0] : crz_reg[MAG_W-1:0];
                if (cross_zero)
                begin
                    status_reg <= tfn_pkg::ST_ZERO_AREA;
                end
            end
            S_NORM:
            begin
                // One bit a cycle until the largest magnitude sits in [2^29, 2^30)
                if (norm_hi)
                begin
                    mx_reg <= mx_reg >> 1;
                    my_reg <= my_reg >> 1;
                    mz_reg <= mz_reg >> 1;
                end
                else if (norm_lo)
                begin
                    mx_reg <= mx_reg << 1;
                    my_reg <= my_reg << 1;
                    mz_reg <= mz_reg << 1;
                end
            end
            S_SQUARE:
            begin
                case (step_reg)
                    4'd1: v_reg <= prod_u;
                    4'd2: v_reg <= v_reg + prod_u;
                    4'd3:
                    begin
                        v_reg   <= v_reg + prod_u;
                        r_reg   <= '0;
                        bit_reg <= ROOT_BIT0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SQRT:
            begin
                // Digit-by-digit integer square root
                if (cs_res.ge)
                begin
                    v_reg <= cs_res.diff;
                    r_reg <= (r_reg >> 1) | bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit a cycle
                if (step_reg == '0)
                begin
                    rem_reg <= div_num;
                    d_reg   <= div_den;
                    q_reg   <= '0;
                end
                else
                begin
                    if (cs_res.ge)
                    begin
                        rem_reg <= cs_res.diff[DIV_W-1:0];
                    end
                    d_reg <= d_reg >> 1;
                    q_reg <= q_next;
                    if (step_reg == DIV_LAST)
                    begin
                        case (comp_reg)
                            2'd0:    nx_reg <= n_val;
                            2'd1:    ny_reg <= n_val;
                            default: nz_reg <= n_val;
                        endcase
                    end
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    out_data_reg <= {{PAD_W{1'b0}}, sidx_reg, nz_reg, ny_reg, nx_reg};
                    out_user_reg <= status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Checks
    logic signed [NORM_W-1:0] out_nx, out_ny, out_nz;

    assign out_nx = m_axis_tdata[15:0];
    assign out_ny = m_axis_tdata[31:16];
    assign out_nz = m_axis_tdata[47:32];

    `TFN_ASSERT_ALWAYS(a_count_range, count_reg <= FULL_COUNT, "corner count beyond table")
    `TFN_ASSERT_NEXT(a_count_step, s_fire && (in_op == tfn_pkg::OP_STORE) && !table_full, count_reg == ($past(count_reg) + 1'b1), "store did not advance count")
    `TFN_ASSERT_IMPLY(a_norm_window, state_reg == S_SQUARE, (mag_or[MAG_W-1:NMAG_W] == '0) && mag_or[NMAG_W-1], "magnitudes not normalized")
    `TFN_ASSERT_IMPLY(a_root_range, state_reg == S_DIV, (r_reg[WIDE_W-1:31] == '0) && (r_reg[29] || r_reg[30]), "root outside expected range")
    `TFN_ASSERT_IMPLY(a_unit_range, m_axis_tvalid && (m_axis_tuser == tfn_pkg::ST_OK), (out_nx <= 16'sd16384) && (out_nx >= -16'sd16384) && (out_ny <= 16'sd16384) && (out_ny >= -16'sd16384) && (out_nz <= 16'sd16384) && (out_nz >= -16'sd16384), "normal component out of range")

endmodule

// ----- tb/sv/triangle_face_normal_test.sv -----
// Self-checking stream testbench for the triangle face normal block.
module triangle_face_normal_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tfn_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int CMAX         = 8388607;
    localparam int CMIN         = -8388608;
    localparam int N_DIRECTED   = 21;
    localparam int N_RANDOM     = 1880;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 2500;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    // Fields of one input item
    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [INDEX_W-1:0]        a;
        logic [INDEX_W-1:0]        b;
        logic [INDEX_W-1:0]        c;
    } corner_item_t;

    // Fields of one result item
    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [STATUS_W-1:0]      status;
        logic [INDEX_W-1:0]       idx;
    } normal_result_t;

    typedef struct {
        logic                op;
        int                  x, y, z;
        int                  a, b, c;
        bit                  fixed;
        int                  nx, ny, nz;
        logic [STATUS_W-1:0] status;
        int                  idx;
    } directed_row_t;

    typedef enum int {POS_WIDE, POS_TINY, POS_EDGE, POS_REPEAT} pos_style_e;

    // Directed rows: extremes, collinear and repeated corners, bad indices, axis normals
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{OP_FACE,  0, 0, 0,          0, 0, 0,     1, 0, 0, 0,      ST_BAD_INDEX, 0},
        '{OP_STORE, 0, 0, 0,          0, 0, 0,     1, 0, 0, 0,      ST_STORED,    0},
        '{OP_STORE, CMAX, CMAX, CMAX, 0, 0, 0,     1, 0, 0, 0,      ST_STORED,    1},
        '{OP_STORE, CMIN, CMIN, CMIN, 0, 0, 0,     1, 0, 0, 0,      ST_STORED,    2},
        '{OP_FACE,  0, 0, 0,          0, 1, 2,     1, 0, 0, 0,      ST_ZERO_AREA, 0},
        '{OP_STORE, CMAX, CMIN, 0,    0, 0, 0,     1, 0, 0, 0,      ST_STORED,    3},
        '{OP_STORE, CMIN, 0, CMAX,    0, 0, 0,     1, 0, 0, 0,      ST_STORED,    4},
        '{OP_FACE,  0, 0, 0,          0, 3, 4,     0, 0, 0, 0,      ST_OK,        0},
        '{OP_FACE,  0, 0, 0,          3, 4, 1,     0, 0, 0, 0,      ST_OK,        0},
        '{OP_FACE,  0, 0, 0,          1, 1, 0,     1, 0, 0, 0,      ST_ZERO_AREA, 0},
        '{OP_STORE, 1, 0, 0,          0, 0, 0,     1, 0, 0, 0,      ST_STORED,    5},
        '{OP_STORE, 0, 1, 0,          0, 0, 0,     1, 0, 0, 0,      ST_STORED,    6},
        '{OP_FACE,  0, 0, 0,          0, 5, 6,     1, 0, 0, 16384,  ST_OK,        0},
        '{OP_FACE,  0, 0, 0,          0, 6, 5,     1, 0, 0, -16384, ST_OK,        0},
        '{OP_FACE,  0, 0, 0,          1023, 0, 0,  1, 0, 0, 0,      ST_BAD_INDEX, 0},
        '{OP_FACE,  0, 0, 0,          0, 1023, 0,  1, 0, 0, 0,      ST_BAD_INDEX, 0},
        '{OP_FACE,  0, 0, 0,          0, 0, 7,     1, 0, 0, 0,      ST_BAD_INDEX, 0},
        '{OP_STORE, -1, -1, -1,       0, 0, 0,     1, 0, 0, 0,      ST_STORED,    7},
        '{OP_FACE,  0, 0, 0,          7, 0, 5,     0, 0, 0, 0,      ST_OK,        0},
        '{OP_FACE,  0, 0, 0,          2, 4, 3,     0, 0, 0, 0,      ST_OK,        0},
        '{OP_FACE,  0, 0, 0,          3, 4, 7,     0, 0, 0, 0,      ST_OK,        0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata;
    logic                     s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0]      m_axis_tuser;

    // Shadow copy of the corner table and count
    int             corner_pos [TABLE_DEPTH][3];
    int             corner_count;
    normal_result_t expected_normals [$];
    int             mismatches;
    int             results_seen;
    int             cycle_cnt;
    bit             quiet;
    bit             sender_calm;

    triangle_face_normal i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Integer square root, floor
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned probe;
        longint unsigned rem;
        r     = 0;
        rem   = v;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rem >= r + probe)
            begin
                rem = rem - (r + probe);
                r   = (r >> 1) + probe;
            end
            else
                r = r >> 1;
            probe >>= 2;
        end
        return r;
    endfunction

    // Expected result of one item; updates the shadow table on a store
    function automatic normal_result_t predict_corner_op(input corner_item_t it);
        normal_result_t           res;
        int                       idx [3];
        longint                   e1 [3];
        longint                   e2 [3];
        longint                   cr [3];
        longint unsigned          mag [3];
        longint unsigned          top;
        longint unsigned          sq;
        longint unsigned          q;
        logic signed [NORM_W-1:0] comp [3];
        res = '0;
        if (it.op == OP_STORE)
        begin
            if (corner_count < TABLE_DEPTH)
            begin
                corner_pos[corner_count][0] = int'(it.x);
                corner_pos[corner_count][1] = int'(it.y);
                corner_pos[corner_count][2] = int'(it.z);
                res.status = ST_STORED;
                res.idx    = INDEX_W'(corner_count);
                corner_count++;
            end
            else
                res.status = ST_FULL;
            return res;
        end
        if (it.a >= corner_count || it.b >= corner_count || it.c >= corner_count)
        begin
            res.status = ST_BAD_INDEX;
            return res;
        end
        idx[0] = it.a;
        idx[1] = it.b;
        idx[2] = it.c;
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = longint'(corner_pos[idx[1]][k]) - longint'(corner_pos[idx[0]][k]);
            e2[k] = longint'(corner_pos[idx[2]][k]) - longint'(corner_pos[idx[0]][k]);
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        top = 0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = (cr[k] < 0) ? longint'(-cr[k]) : longint'(cr[k]);
            if (mag[k] > top)
                top = mag[k];
        end
        if (top == 0)
        begin
            res.status = ST_ZERO_AREA;
            return res;
        end
        // Block-normalize so the largest magnitude lands in [2^29, 2^30)
        while (top >= (64'd1 << 30))
        begin
            top >>= 1;
            for (int k = 0; k < 3; k++)
                mag[k] >>= 1;
        end
        while (top < (64'd1 << 29))
        begin
            top <<= 1;
            for (int k = 0; k < 3; k++)
                mag[k] <<= 1;
        end
        sq = root_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        for (int k = 0; k < 3; k++)
        begin
            q       = (mag[k] * 64'd16384 + sq / 2) / sq;
            comp[k] = NORM_W'(q);
            if (cr[k] < 0)
                comp[k] = -comp[k];
        end
        res.nx     = comp[0];
        res.ny     = comp[1];
        res.nz     = comp[2];
        res.status = ST_OK;
        return res;
    endfunction

    // Offer one item, optionally after an idle burst; predict when it is taken
    task automatic send_item(input corner_item_t it, input bit fixed,
                             input normal_result_t fixed_res);
        normal_result_t res;
        if (!quiet && !sender_calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {2'b00, it.c, it.b, it.a, it.z, it.y, it.x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = predict_corner_op(it);
        if (fixed)
            res = fixed_res;
        expected_normals.push_back(res);
    endtask

    // Random corner coordinate in the given style
    function automatic int pick_coord(input pos_style_e style, input int axis);
        int r;
        case (style)
            POS_TINY:   return $urandom_range(0, 32) - 16;
            POS_EDGE:
            begin
                r = $urandom_range(0, 4);
                return (r == 0) ? CMAX : (r == 1) ? CMIN : (r == 2) ? 0 : (r == 3) ? 1 : -1;
            end
            POS_REPEAT:
            begin
                if (corner_count == 0)
                    return int'($signed(COORD_W'($urandom)));
                return corner_pos[$urandom_range(0, corner_count - 1)][axis];
            end
            default:    return int'($signed(COORD_W'($urandom)));
        endcase
    endfunction

    // Stimulus: directed table, then random stores and faces
    initial
    begin
        corner_item_t   it;
        normal_result_t fres;
        pos_style_e     style;
        int             cnt;
        int             r;
        int             rep;
        int             dup_src;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        corner_count  = 0;
        mismatches    = 0;
        quiet         = 1'b0;
        sender_calm   = 1'b0;
        style         = POS_WIDE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            it.op       = directed_rows[i].op;
            it.x        = COORD_W'(directed_rows[i].x);
            it.y        = COORD_W'(directed_rows[i].y);
            it.z        = COORD_W'(directed_rows[i].z);
            it.a        = INDEX_W'(directed_rows[i].a);
            it.b        = INDEX_W'(directed_rows[i].b);
            it.c        = INDEX_W'(directed_rows[i].c);
            fres.nx     = NORM_W'(directed_rows[i].nx);
            fres.ny     = NORM_W'(directed_rows[i].ny);
            fres.nz     = NORM_W'(directed_rows[i].nz);
            fres.status = directed_rows[i].status;
            fres.idx    = INDEX_W'(directed_rows[i].idx);
            send_item(it, directed_rows[i].fixed, fres);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            quiet       = (n >= N_RANDOM - QUIET_TAIL);
            sender_calm = ((n / 100) % 3 == 2);
            it.x = COORD_W'($urandom);
            it.y = COORD_W'($urandom);
            it.z = COORD_W'($urandom);
            it.a = INDEX_W'($urandom);
            it.b = INDEX_W'($urandom);
            it.c = INDEX_W'($urandom);
            cnt  = corner_count;
            if ($urandom_range(0, 99) < 58)
            begin
                // Store; the coordinate style sticks for a few stores
                it.op = OP_STORE;
                if ($urandom_range(0, 4) == 0)
                    style = pos_style_e'($urandom_range(0, 3));
                if (style == POS_REPEAT && cnt > 0)
                begin
                    dup_src = $urandom_range(0, cnt - 1);
                    it.x = COORD_W'(corner_pos[dup_src][0]);
                    it.y = COORD_W'(corner_pos[dup_src][1]);
                    it.z = COORD_W'(corner_pos[dup_src][2]);
                end
                else if (style != POS_WIDE)
                begin
                    it.x = COORD_W'(pick_coord(style, 0));
                    it.y = COORD_W'(pick_coord(style, 1));
                    it.z = COORD_W'(pick_coord(style, 2));
                end
            end
            else
            begin
                it.op = OP_FACE;
                r = $urandom_range(0, 99);
                if (r < 15 || cnt < 3)
                    ; // raw 10-bit indices, mostly out of range early on
                else if (r < 35)
                begin
                    // the three newest corners, often of one style
                    it.a = INDEX_W'(cnt - 3);
                    it.b = INDEX_W'(cnt - 2);
                    it.c = INDEX_W'(cnt - 1);
                end
                else
                begin
                    it.a = INDEX_W'($urandom_range(0, cnt - 1));
                    it.b = INDEX_W'($urandom_range(0, cnt - 1));
                    it.c = INDEX_W'($urandom_range(0, cnt - 1));
                    rep  = $urandom_range(0, 9);
                    // repeated corner
                    if (rep == 0)
                        it.b = it.a;
                    else if (rep == 1)
                        it.c = it.a;
                    // one index just at the count
                    else if (rep == 2 && cnt < TABLE_DEPTH)
                        it.c = INDEX_W'(cnt);
                end
            end
            send_item(it, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        // Drain
        while (expected_normals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_normals.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, calm stretches
    initial
    begin
        int  stall_left;
        bit  hold_done;
        stall_left    = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && (cycle_cnt / 512) % 3 != 1 && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
                m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        normal_result_t got;
        normal_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.nx     = m_axis_tdata[15:0];
            got.ny     = m_axis_tdata[31:16];
            got.nz     = m_axis_tdata[47:32];
            got.idx    = m_axis_tdata[57:48];
            got.status = m_axis_tuser;
            results_seen++;
            if (expected_normals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: n=(%0d,%0d,%0d) status=%0d idx=%0d",
                             got.nx, got.ny, got.nz, got.status, got.idx);
            end
            else
            begin
                want = expected_normals.pop_front();
                if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                    got.status !== want.status || got.idx !== want.idx)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected n=(%0d,%0d,%0d) status=%0d idx=%0d, got n=(%0d,%0d,%0d) status=%0d idx=%0d",
                                 results_seen, want.nx, want.ny, want.nz, want.status,
                                 want.idx, got.nx, got.ny, got.nz, got.status, got.idx);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_cnt    = 0;
        results_seen = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_corner_mem.sv
hw/rtl/tfn_mul.sv
hw/rtl/tfn_csub.sv
hw/rtl/triangle_face_normal.sv
tb/sv/triangle_face_normal_test.sv
